// File: design/eigenvalue_key_heapsort_macros.svh
// assertion macros for the eigenvalue key heapsort block
// used by the port checker; no other dependencies
`ifndef EIGENVALUE_KEY_HEAPSORT_MACROS_SVH
`define EIGENVALUE_KEY_HEAPSORT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define EKS_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("eks assertion failed");

// clocked assertion on the block clock and reset
`define EKS_ASSERT(label, prop) \
  `EKS_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// File: design/eks_pkg.sv
// shared types, sizes and codes for the eigenvalue key heapsort block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package eks_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int KEY_W       = 2 * DATA_W;
  localparam int IN_TDATA_W  = 3 * DATA_W;
  localparam int OUT_TDATA_W = ((3 * DATA_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * DATA_W - IDX_W;

  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  // configuration register indexes
  localparam logic REG_KEY_SELECT   = 1'b0;
  localparam logic REG_VARIANT_FLIP = 1'b1;

  typedef enum logic [1:0] {
    KEY_MODULUS  = 2'd0,
    KEY_RESIDUAL = 2'd1,
    KEY_REAL     = 2'd2,
    KEY_IMAG     = 2'd3
  } key_sel_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] residual;
    logic signed [DATA_W-1:0] imag_part;
    logic signed [DATA_W-1:0] real_part;
  } record_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } heap_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    heap_entry_t      wdata;
    logic             re;
    logic [IDX_W-1:0] raddr0;
    logic [IDX_W-1:0] raddr1;
  } heap_req_t;

endpackage

// File: design/eigenvalue_key_heapsort.sv
// a record is registered on acceptance, then written to both stores; after the last record the heap
// is sorted in place, each build or extraction step taking an entry and sifting it down, one heap
// read, then one compare and write-back per level; results come from heap and then record reads.
// new records are taken only in the idle state, not during a store write, the sort or emission.
// reset: asynchronous active low; clears the record count, state and output valid, config to 0.
// memories need no clearing pass: only entries written in the current set are used.
`timescale 1ns / 1ps

module eigenvalue_key_heapsort (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream: real_part [31:0], imag_part [63:32], residual [95:64]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [eks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  // master stream: out_real [31:0], out_imag [63:32], out_residual [95:64],
  // original_index [101:96], zero pad above
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [eks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [1:0]                         cfg_data_i
);

  localparam int IW = eks_pkg::IDX_W;
  localparam int CW = eks_pkg::CNT_W;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_LD_WR     = 11'b000_0000_0010,
    ST_OUTER     = 11'b000_0000_0100,
    ST_TAKE_K    = 11'b000_0000_1000,
    ST_TAKE_IR   = 11'b000_0001_0000,
    ST_FINAL     = 11'b000_0010_0000,
    ST_SIFT_CHK  = 11'b000_0100_0000,
    ST_SIFT_CMP  = 11'b000_1000_0000,
    ST_EMIT_RDH  = 11'b001_0000_0000,
    ST_EMIT_RDS  = 11'b010_0000_0000,
    ST_EMIT_LOAD = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     k_q, k_d;
  logic [CW-1:0]     ir_q, ir_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW:0]       j_q, j_d;
  logic [IW-1:0]     p_q, p_d;
  logic              out_valid_q, out_valid_d;

  eks_pkg::heap_entry_t hold_q, hold_d;
  eks_pkg::record_t     rec_q;
  logic                 last_q;
  eks_pkg::record_t     out_rec_q;
  logic [IW-1:0]        out_idx_q;
  logic                 out_last_q;
  logic [IW-1:0]        idx_q;
  logic                 out_load;

  eks_pkg::key_sel_e    key_select_q;
  logic                 variant_flip_q;

  logic                 accept;
  logic [eks_pkg::KEY_W-1:0] key;
  eks_pkg::heap_req_t   heap_req;
  eks_pkg::heap_entry_t heap_rd0, heap_rd1;
  logic                 rec_we, rec_re;
  logic [IW-1:0]        rec_raddr;
  eks_pkg::record_t     rec_rd;

  logic                 full, rev, pick_r, down;
  logic [CW-1:0]        cnt_inc, cnt_new, k_dec, k_dec2, ir_dec, i_dec, n_dec;
  logic [CW-1:0]        rev_pos, p_inc, i_next;
  logic [CW:0]          j_dec, j_inc;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign full    = (count_q == CW'(eks_pkg::MAX_RECORDS));
  assign cnt_inc = count_q + CW'(1);
  assign cnt_new = full ? count_q : cnt_inc;
  assign k_dec   = k_q - CW'(1);
  assign k_dec2  = k_q - CW'(2);
  assign ir_dec  = ir_q - CW'(1);
  assign i_dec   = i_q - CW'(1);
  assign n_dec   = n_q - CW'(1);
  assign j_dec   = j_q - (CW+1)'(1);
  assign j_inc   = j_q + (CW+1)'(1);
  assign rev_pos = n_dec - {1'b0, p_q};
  assign p_inc   = {1'b0, p_q} + CW'(1);
  assign rev     = (key_select_q != eks_pkg::KEY_RESIDUAL) ^ variant_flip_q;

  // three compares side by side: left vs right child, hold vs each child
  assign pick_r = (j_q < {1'b0, ir_q}) && (heap_rd0.key < heap_rd1.key);
  assign down   = pick_r ? (hold_q.key < heap_rd1.key) : (hold_q.key < heap_rd0.key);
  assign i_next = pick_r ? j_inc[CW-1:0] : j_q[CW-1:0];

  assign out_load = 1'b0 || ((state_q == ST_EMIT_LOAD) && (!out_valid_q || m_axis_tready));

  eks_key_gen u_key_gen (
    .clk_i      (clk_i),
    .load_i     (accept),
    .real_i     (s_axis_tdata[eks_pkg::DATA_W-1:0]),
    .imag_i     (s_axis_tdata[2*eks_pkg::DATA_W-1:eks_pkg::DATA_W]),
    .residual_i (s_axis_tdata[3*eks_pkg::DATA_W-1:2*eks_pkg::DATA_W]),
    .sel_i      (key_select_q),
    .key_o      (key)
  );

  eks_record_mem u_record_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (rec_q),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rd)
  );

  eks_heap_mem u_heap_mem (
    .clk_i    (clk_i),
    .req_i    (heap_req),
    .rdata0_o (heap_rd0),
    .rdata1_o (heap_rd1)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    k_d         = k_q;
    ir_d        = ir_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    hold_d      = hold_q;
    heap_req    = '0;
    rec_we      = 1'b0;
    rec_re      = 1'b0;
    rec_raddr   = heap_rd0.idx;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LD_WR;
        end
      end
      ST_LD_WR: begin
        if (!full) begin
          rec_we              = 1'b1;
          heap_req.we         = 1'b1;
          heap_req.waddr      = count_q[IW-1:0];
          heap_req.wdata.key  = key;
          heap_req.wdata.idx  = count_q[IW-1:0];
          count_d             = cnt_inc;
        end
        if (last_q) begin
          count_d = '0;
          n_d     = cnt_new;
          k_d     = {1'b0, cnt_new[CW-1:1]} + CW'(1);
          ir_d    = cnt_new;
          p_d     = '0;
          // a single record needs no sort
          state_d = (cnt_new > CW'(1)) ? ST_OUTER : ST_EMIT_RDH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUTER: begin
        heap_req.re = 1'b1;
        if (k_q > CW'(1)) begin
          k_d             = k_dec;
          heap_req.raddr0 = k_dec2[IW-1:0];
          state_d         = ST_TAKE_K;
        end else begin
          heap_req.raddr0 = ir_dec[IW-1:0];
          heap_req.raddr1 = '0;
          state_d         = ST_TAKE_IR;
        end
      end
      ST_TAKE_K: begin
        hold_d  = heap_rd0;
        i_d     = k_q;
        j_d     = {k_q, 1'b0};
        state_d = ST_SIFT_CHK;
      end
      ST_TAKE_IR: begin
        // move the root to the end of the shrinking heap
        hold_d         = heap_rd0;
        heap_req.we    = 1'b1;
        heap_req.waddr = ir_dec[IW-1:0];
        heap_req.wdata = heap_rd1;
        ir_d           = ir_dec;
        if (ir_q == CW'(2)) begin
          state_d = ST_FINAL;
        end else begin
          i_d     = CW'(1);
          j_d     = (CW+1)'(2);
          state_d = ST_SIFT_CHK;
        end
      end
      ST_FINAL: begin
        heap_req.we    = 1'b1;
        heap_req.waddr = '0;
        heap_req.wdata = hold_q;
        state_d        = ST_EMIT_RDH;
      end
      ST_SIFT_CHK: begin
        if (j_q <= {1'b0, ir_q}) begin
          heap_req.re     = 1'b1;
          heap_req.raddr0 = j_dec[IW-1:0];
          heap_req.raddr1 = j_q[IW-1:0];
          state_d         = ST_SIFT_CMP;
        end else begin
          heap_req.we    = 1'b1;
          heap_req.waddr = i_dec[IW-1:0];
          heap_req.wdata = hold_q;
          state_d        = ST_OUTER;
        end
      end
      ST_SIFT_CMP: begin
        heap_req.we    = 1'b1;
        heap_req.waddr = i_dec[IW-1:0];
        if (down) begin
          heap_req.wdata = pick_r ? heap_rd1 : heap_rd0;
          i_d            = i_next;
          j_d            = {i_next, 1'b0};
          state_d        = ST_SIFT_CHK;
        end else begin
          heap_req.wdata = hold_q;
          state_d        = ST_OUTER;
        end
      end
      ST_EMIT_RDH: begin
        heap_req.re     = 1'b1;
        heap_req.raddr0 = rev ? rev_pos[IW-1:0] : p_q;
        state_d         = ST_EMIT_RDS;
      end
      ST_EMIT_RDS: begin
        rec_re  = 1'b1;
        state_d = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (p_inc == n_q) begin
            state_d = ST_IDLE;
          end else begin
            p_d     = p_inc[IW-1:0];
            state_d = ST_EMIT_RDH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
      ir_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      k_q         <= k_d;
      ir_q        <= ir_d;
      i_q         <= i_d;
      j_q         <= j_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_select_q   <= eks_pkg::KEY_MODULUS;
      variant_flip_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        eks_pkg::REG_KEY_SELECT:   key_select_q   <= eks_pkg::key_sel_e'(cfg_data_i);
        eks_pkg::REG_VARIANT_FLIP: variant_flip_q <= cfg_data_i[0];
        default:                   variant_flip_q <= variant_flip_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    if (accept) begin
      rec_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (rec_re) begin
      idx_q <= heap_rd0.idx;
    end
    if (out_load) begin
      out_rec_q  <= rec_rd;
      out_idx_q  <= idx_q;
      out_last_q <= (p_inc == n_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{eks_pkg::OUT_PAD_W{1'b0}}, out_idx_q, out_rec_q};

endmodule

// File: design/eks_key_gen.sv
// sort key former: registered squares for the modulus key, offset signed keys
// depends on eks_pkg
`timescale 1ns / 1ps

module eks_key_gen (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic signed [eks_pkg::DATA_W-1:0]   real_i,
  input  logic signed [eks_pkg::DATA_W-1:0]   imag_i,
  input  logic signed [eks_pkg::DATA_W-1:0]   residual_i,
  input  eks_pkg::key_sel_e                   sel_i,
  output logic        [eks_pkg::KEY_W-1:0]    key_o
);

  logic signed [eks_pkg::KEY_W-1:0]  sq_re_d, sq_im_d;
  logic        [eks_pkg::KEY_W-1:0]  sq_re_q, sq_im_q;
  logic        [eks_pkg::DATA_W-1:0] raw_d, raw_q;
  eks_pkg::key_sel_e                 sel_q;

  assign sq_re_d = real_i * real_i;
  assign sq_im_d = imag_i * imag_i;

  always_comb begin
    unique case (sel_i)
      eks_pkg::KEY_RESIDUAL: raw_d = residual_i;
      eks_pkg::KEY_REAL:     raw_d = real_i;
      eks_pkg::KEY_IMAG:     raw_d = imag_i;
      default:               raw_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sq_re_q <= sq_re_d;
      sq_im_q <= sq_im_d;
      raw_q   <= raw_d;
      sel_q   <= sel_i;
    end
  end

  // signed kinds get the sign bit flipped so all keys compare unsigned
  always_comb begin
    unique case (sel_q)
      eks_pkg::KEY_MODULUS: key_o = sq_re_q + sq_im_q;
      default:              key_o = {{(eks_pkg::KEY_W-eks_pkg::DATA_W){1'b0}},
                                     raw_q ^ eks_pkg::SIGN_FLIP};
    endcase
  end

endmodule

// File: design/eks_record_mem.sv
// record store: one write port, one registered read port
// depends on eks_pkg
`timescale 1ns / 1ps

module eks_record_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [eks_pkg::IDX_W-1:0]   waddr_i,
  input  eks_pkg::record_t            wdata_i,
  input  logic                        re_i,
  input  logic [eks_pkg::IDX_W-1:0]   raddr_i,
  output eks_pkg::record_t            rdata_o
);

  eks_pkg::record_t mem_q [eks_pkg::MAX_RECORDS];
  eks_pkg::record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/eks_heap_mem.sv
// heap of keys and load positions: one write port, two registered read ports
// depends on eks_pkg
`timescale 1ns / 1ps

module eks_heap_mem (
  input  logic                  clk_i,
  input  eks_pkg::heap_req_t    req_i,
  output eks_pkg::heap_entry_t  rdata0_o,
  output eks_pkg::heap_entry_t  rdata1_o
);

  eks_pkg::heap_entry_t mem_q [eks_pkg::MAX_RECORDS];
  eks_pkg::heap_entry_t rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata0_q <= mem_q[req_i.raddr0];
      rdata1_q <= mem_q[req_i.raddr1];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: design/eks_checker.sv
// port-level checker for the eigenvalue key heapsort block, bound to the top level
// depends on eks_pkg and eigenvalue_key_heapsort_macros.svh
`timescale 1ns / 1ps
`include "eigenvalue_key_heapsort_macros.svh"

module eks_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [eks_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic in_xfer;
  logic out_wait;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // a record is written into the stores, unless they are full, the cycle after its transaction
  `EKS_ASSERT(a_busy_after_accept, in_xfer |=> !s_axis_tready)

  // a record that does not close the set frees the input once it has been written into the stores
  `EKS_ASSERT(a_ready_after_load, in_xfer && !s_axis_tlast |=> ##1 s_axis_tready)

  `EKS_ASSERT(a_out_valid_holds, out_wait |=> m_axis_tvalid)

  `EKS_ASSERT(a_out_data_holds, out_wait |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind eigenvalue_key_heapsort eks_checker u_eks_checker (.*);

// File: tb/tb.sv
// self-checking testbench for the eigenvalue key heapsort block
// depends on eks_pkg and eigenvalue_key_heapsort; predicts each sorted set in-line
`timescale 1ns / 1ps

module tb;
  import eks_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_index_i;
  logic [1:0]             cfg_data_i;

  eigenvalue_key_heapsort dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  typedef struct {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [DATA_W-1:0] rs;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } sorted_rec_t;

  // records still owed by the block, in emission order
  sorted_rec_t sorted_q[$];

  // shadow of the block: held records, their keys and the registers
  logic [DATA_W-1:0] real_mem [MAX_RECORDS];
  logic [DATA_W-1:0] imag_mem [MAX_RECORDS];
  logic [DATA_W-1:0] res_mem  [MAX_RECORDS];
  logic [KEY_W-1:0]  key_mem  [MAX_RECORDS];
  int                held;
  key_sel_e          key_sel_q;
  logic              flip_q;

  // heap workspace, entries 1..n
  logic [KEY_W-1:0]  sort_key [MAX_RECORDS+1];
  int                sort_ord [MAX_RECORDS+1];

  int err_count;
  int items_sent;
  int sets_done;
  int results_seen;
  bit gap_on;
  bit stall_on;
  int in_gap;
  bit in_offer;
  int hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [KEY_W-1:0] record_key(record_t r, key_sel_e sel);
    longint a;
    longint b;
    a = r.real_part;
    b = r.imag_part;
    case (sel)
      KEY_MODULUS:  return a * a + b * b;
      KEY_RESIDUAL: return {32'd0, r.residual ^ SIGN_FLIP};
      KEY_REAL:     return {32'd0, r.real_part ^ SIGN_FLIP};
      default:      return {32'd0, r.imag_part ^ SIGN_FLIP};
    endcase
  endfunction

  // ascending sift-down heapsort with strict compares, ties land as the classic loop puts them
  function automatic void heap_sort_keys(int n);
    int i, j, k, ir, lm;
    logic [KEY_W-1:0] xm;
    k = n / 2 + 1;
    ir = n;
    while (1'b1) begin
      if (k > 1) begin
        k--;
        lm = sort_ord[k];
        xm = sort_key[k];
      end else begin
        lm = sort_ord[ir];
        xm = sort_key[ir];
        sort_key[ir] = sort_key[1];
        sort_ord[ir] = sort_ord[1];
        ir--;
        if (ir == 1) begin
          sort_ord[1] = lm;
          sort_key[1] = xm;
          return;
        end
      end
      i = k;
      j = k + k;
      while (j <= ir) begin
        if (j < ir && sort_key[j] < sort_key[j+1]) j++;
        if (xm < sort_key[j]) begin
          sort_ord[i] = sort_ord[j];
          sort_key[i] = sort_key[j];
          i = j;
          j = j + j;
        end else begin
          j = ir + 1;
        end
      end
      sort_ord[i] = lm;
      sort_key[i] = xm;
    end
  endfunction

  task automatic load_record(record_t r, logic last);
    int n, src;
    bit rev;
    sorted_rec_t item;
    if (held < MAX_RECORDS) begin
      real_mem[held] = r.real_part;
      imag_mem[held] = r.imag_part;
      res_mem[held]  = r.residual;
      key_mem[held]  = record_key(r, key_sel_q);
      held++;
    end
    if (!last) return;
    n = held;
    for (int p = 0; p < n; p++) begin
      sort_key[p+1] = key_mem[p];
      sort_ord[p+1] = p;
    end
    if (n > 1) heap_sort_keys(n);
    rev = (key_sel_q != KEY_RESIDUAL) ^ flip_q;
    for (int p = 0; p < n; p++) begin
      src = rev ? sort_ord[n-p] : sort_ord[p+1];
      item.re   = real_mem[src];
      item.im   = imag_mem[src];
      item.rs   = res_mem[src];
      item.idx  = src[IDX_W-1:0];
      item.last = (p + 1 == n);
      sorted_q.push_back(item);
    end
    held = 0;
    sets_done++;
  endtask

  task automatic send_eigen(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                            input logic [DATA_W-1:0] rs, input logic last);
    record_t rec;
    rec.real_part = re;
    rec.imag_part = im;
    rec.residual  = rs;
    if (in_gap > 0) repeat (in_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rec;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    load_record(rec, last);
    items_sent++;
    in_gap = gap_on ? $urandom_range(0, 14) : 0;
    in_offer = (in_gap == 0);
    if (!in_offer) s_axis_tvalid <= 1'b0;
  endtask

  // drops tvalid and lets the block drain; always advances time after the drop
  task automatic wait_idle();
    if (in_offer) begin
      s_axis_tvalid <= 1'b0;
      in_offer = 1'b0;
      in_gap = 0;
    end
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_KEY_SELECT) key_sel_q = key_sel_e'(val);
    else flip_q = val[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      3, 4:    return 32'($urandom_range(0, 4)) - 32'd2;  // small values make ties
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_set(int size);
    for (int p = 0; p < size; p++)
      send_eigen(rand_value(), rand_value(), rand_value(), p == size - 1);
  endtask

  task automatic test_single_pass();
    write_reg(REG_KEY_SELECT, KEY_MODULUS);
    write_reg(REG_VARIANT_FLIP, 2'd0);
    send_eigen(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 1'b1);
  endtask

  task automatic test_modulus_extremes();
    // largest modulus, equal moduli in different records, zero
    send_eigen(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_eigen(32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff, 1'b0);
    send_eigen(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_eigen(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b0);
    send_eigen(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_eigen(32'h0000_0000, 32'h7fff_ffff, 32'h5555_aaaa, 1'b1);
  endtask

  task automatic test_residual_key();
    write_reg(REG_KEY_SELECT, KEY_RESIDUAL);
    send_eigen(32'h0000_0010, 32'h0000_0020, 32'h8000_0000, 1'b0);
    send_eigen(32'h0000_0011, 32'h0000_0021, 32'h7fff_ffff, 1'b0);
    send_eigen(32'h0000_0012, 32'h0000_0022, 32'h0000_0000, 1'b0);
    send_eigen(32'h0000_0013, 32'h0000_0023, 32'hffff_ffff, 1'b0);
    send_eigen(32'h0000_0014, 32'h0000_0024, 32'h0000_0000, 1'b1);
    write_reg(REG_VARIANT_FLIP, 2'd1);
    send_eigen(32'haaaa_5555, 32'h0000_0001, 32'h0001_0000, 1'b0);
    send_eigen(32'h5555_aaaa, 32'h0000_0002, 32'h0001_0000, 1'b1);
  endtask

  task automatic test_part_keys();
    write_reg(REG_KEY_SELECT, KEY_REAL);
    send_eigen(32'h8000_0000, 32'h0000_0003, 32'h0000_0001, 1'b0);
    send_eigen(32'h7fff_ffff, 32'h0000_0004, 32'h0000_0002, 1'b0);
    send_eigen(32'hffff_ffff, 32'h0000_0005, 32'h0000_0003, 1'b1);
    write_reg(REG_KEY_SELECT, KEY_IMAG);
    write_reg(REG_VARIANT_FLIP, 2'd0);
    send_eigen(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0009, 1'b0);
    send_eigen(32'h0000_0002, 32'h8000_0000, 32'h0000_0008, 1'b0);
    send_eigen(32'h0000_0003, 32'h7fff_ffff, 32'h0000_0007, 1'b1);
  endtask

  // each record keeps the key kind it was loaded with
  task automatic test_key_change_mid_set();
    write_reg(REG_KEY_SELECT, KEY_REAL);
    send_eigen(32'h7fff_ffff, 32'h0000_0001, 32'h0000_0011, 1'b0);
    send_eigen(32'h8000_0000, 32'h0000_0002, 32'h0000_0012, 1'b0);
    write_reg(REG_KEY_SELECT, KEY_IMAG);
    send_eigen(32'h0000_0003, 32'h0000_0000, 32'h0000_0013, 1'b0);
    write_reg(REG_KEY_SELECT, KEY_MODULUS);
    send_eigen(32'h0000_ffff, 32'h0000_ffff, 32'h0000_0014, 1'b1);
  endtask

  // records past the capacity are dropped, the one with tlast still closes the set
  task automatic test_store_full();
    gap_on = 1'b0;
    write_reg(REG_KEY_SELECT, key_sel_e'($urandom_range(0, 3)));
    send_random_set(MAX_RECORDS + 2);
    gap_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    gap_on = 1'b0;
    stall_on = 1'b0;
    hold_cycles = 400;
    send_random_set(12);
    send_random_set(12);
    wait_idle();
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_sets();
    int sel, size, split;
    while (items_sent < 370) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) size = $urandom_range(1, 6);
      else if (sel < 9) size = $urandom_range(7, 16);
      else size = $urandom_range(17, 40);
      gap_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: write_reg(REG_KEY_SELECT, key_sel_e'($urandom_range(0, 3)));
        1: write_reg(REG_VARIANT_FLIP, 2'($urandom_range(0, 1)));
        2: wait_idle();
        default: ;
      endcase
      if (size > 1 && $urandom_range(0, 7) == 0) begin
        split = $urandom_range(1, size - 1);
        for (int p = 0; p < split; p++)
          send_eigen(rand_value(), rand_value(), rand_value(), 1'b0);
        write_reg(REG_KEY_SELECT, key_sel_e'($urandom_range(0, 3)));
        send_random_set(size - split);
      end else begin
        send_random_set(size);
      end
    end
  endtask

  // receiver: random stalls per result, plus a long hold-off on request
  initial begin : receiver
    int pause;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        pause = hold_cycles;
        hold_cycles = 0;
      end else begin
        pause = stall_on ? $urandom_range(0, 14) : 0;
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    sorted_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction: expected none, actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = sorted_q.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.re) begin
          err_count++;
          $display("%0t: out_real expected %h actual %h", $time, want.re,
                   m_axis_tdata[DATA_W-1:0]);
        end
        if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.im) begin
          err_count++;
          $display("%0t: out_imag expected %h actual %h", $time, want.im,
                   m_axis_tdata[2*DATA_W-1:DATA_W]);
        end
        if (m_axis_tdata[3*DATA_W-1:2*DATA_W] !== want.rs) begin
          err_count++;
          $display("%0t: out_residual expected %h actual %h", $time, want.rs,
                   m_axis_tdata[3*DATA_W-1:2*DATA_W]);
        end
        if (m_axis_tdata[3*DATA_W+IDX_W-1:3*DATA_W] !== want.idx) begin
          err_count++;
          $display("%0t: original_index expected %0d actual %0d", $time, want.idx,
                   m_axis_tdata[3*DATA_W+IDX_W-1:3*DATA_W]);
        end
        if (m_axis_tlast !== want.last) begin
          err_count++;
          $display("%0t: last_out expected %b actual %b", $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin : main
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_KEY_SELECT;
    cfg_data_i    = KEY_MODULUS;
    held          = 0;
    key_sel_q     = KEY_MODULUS;
    flip_q        = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    sets_done     = 0;
    results_seen  = 0;
    gap_on        = 1'b1;
    stall_on      = 1'b1;
    in_gap        = 0;
    in_offer      = 1'b0;
    hold_cycles   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pass();
    test_modulus_extremes();
    test_residual_key();
    test_part_keys();
    test_key_change_mid_set();
    test_store_full();
    test_backpressure();
    test_random_sets();

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("sorted %0d records in %0d sets, %0d results checked", items_sent, sets_done,
             results_seen);
    $display("covered all key kinds, both orders, full store, mid-set key changes, stalls");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
